@@ sv/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// shared types, codes and widths of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int DIM_W  = 4;
  localparam int ACC_W  = 40;
  localparam int REG_W  = 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [REG_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [REG_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [REG_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [REG_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } mme_cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } mme_cfg_t;

endpackage

@@ sv/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// general matrix multiply on two small element stores
// ----------------------------------------------------------------------------
// usage: items on the s_ channel write an element of A (tuser 0) or B
// (tuser 1) at a row and column, or start a product (tuser 2). element
// writes out of range and tuser 3 are dropped. sizes come from the four
// dimension registers on the cfg port, for the user to write only while
// the block is idle, which the block does not enforce; each is clamped
// to 1..MAX_DIM. a product gives one m_ item per cell in row-major
// order, tlast on the final cell; with a_cols not equal to b_rows it
// gives a single item with tuser set and tlast set instead.
// throughput: element writes go at one item per cycle through a four
// entry command queue while it is not full. a product does one store read
// per inner step for each cell, then the read, multiply and accumulate
// registers drain into the result register; a size error goes straight
// there. further items queue up behind a product until the queue fills.
// reset: registers go to 8, queue and result register empty; the stores
// are not cleared. a stalled receiver holds the result register, and the
// back end waits with it.
// ----------------------------------------------------------------------------
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [REG_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [OP_W-1:0]   s_tuser,   // operation
  input  logic [23:0]       s_tdata,   // row_index, col_index, element_value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata,   // out_row, out_col, out_value
  output logic              m_tlast,
  output logic              m_tuser    // dim_error
);

  mme_cfg_t                cfg;
  mme_cmd_t                push_cmd;
  mme_cmd_t                q_cmd;
  logic                    q_push;
  logic                    q_pop;
  logic                    q_empty;
  logic                    q_full;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [ACC_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_rows <= DIM_RESET;
      cfg.a_cols <= DIM_RESET;
      cfg.b_rows <= DIM_RESET;
      cfg.b_cols <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A_ROWS: cfg.a_rows <= cfg_data;
        REG_A_COLS: cfg.a_cols <= cfg_data;
        REG_B_ROWS: cfg.b_rows <= cfg_data;
        REG_B_COLS: cfg.b_cols <= cfg_data;
      endcase
    end
  end

  mme_front #(.MAX_DIM(MAX_DIM)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  mme_queue #(.DEPTH(4)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  mme_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_cmd     (q_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

  assign m_tdata = {2'b00, out_value, out_col, out_row};

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[45:0] == '0)))
    else $error("size error item not a lone zero item");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((DIM_W'(m_tdata[2:0]) < DIM_W'(MAX_DIM)) &&
                  (DIM_W'(m_tdata[5:3]) < DIM_W'(MAX_DIM))))
    else $error("result cell outside matrix");
`endif

endmodule

@@ sv/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mme_front.sv @@
// ----------------------------------------------------------------------------
// mme_front
// accepts input items, drops out of range writes and unused operations
// ----------------------------------------------------------------------------
module mme_front import mme_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [OP_W-1:0]       s_tuser,
  input  logic [23:0]           s_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output mme_cmd_t              q_cmd
);

  logic keep;
  logic in_range;

  assign q_cmd.op    = s_tuser;
  assign q_cmd.row   = s_tdata[2:0];
  assign q_cmd.col   = s_tdata[5:3];
  assign q_cmd.value = s_tdata[21:6];

  assign in_range = (DIM_W'(q_cmd.row) < DIM_W'(MAX_DIM)) &&
                    (DIM_W'(q_cmd.col) < DIM_W'(MAX_DIM));

  always_comb begin
    unique case (q_cmd.op)
      OP_WRITE_A: keep = in_range;
      OP_WRITE_B: keep = in_range;
      OP_COMPUTE: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready && keep;

endmodule

@@ sv/mme_queue.sv @@
// ----------------------------------------------------------------------------
// mme_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mme_queue import mme_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  mme_cmd_t push_cmd,
  input  logic     pop,
  output mme_cmd_t head,
  output logic     empty,
  output logic     full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mme_cmd_t        entry [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ sv/mme_back.sv @@
// ----------------------------------------------------------------------------
// mme_back
// element stores, multiply-accumulate sequencer and result register
// ----------------------------------------------------------------------------
module mme_back import mme_pkg::*; #(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mme_cfg_t                cfg,
  input  mme_cmd_t                q_cmd,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [ACC_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_err
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * ELEM_WIDTH;
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [IDX_W-1:0]        i;
  logic [IDX_W-1:0]        j;
  logic [IDX_W-1:0]        k;
  logic [DIM_W-1:0]        ar;
  logic [DIM_W-1:0]        ac;
  logic [DIM_W-1:0]        bc;
  logic                    err;
  logic                    s1_valid;
  logic                    s1_first;
  logic                    s1_last;
  logic                    s2_valid;
  logic                    s2_first;
  logic                    s2_last;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic                    done;

  logic                    start;
  logic                    mismatch;
  logic                    k_last;
  logic                    j_last;
  logic                    cell_last;
  logic                    load;
  logic                    a_we;
  logic                    b_we;
  logic [AW-1:0]           waddr;
  logic [ELEM_WIDTH-1:0]   wdata;
  logic [AW-1:0]           a_raddr;
  logic [AW-1:0]           b_raddr;
  logic [ELEM_WIDTH-1:0]   a_rd;
  logic [ELEM_WIDTH-1:0]   b_rd;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign start    = q_pop && (q_cmd.op == OP_COMPUTE);
  assign a_we     = q_pop && (q_cmd.op == OP_WRITE_A);
  assign b_we     = q_pop && (q_cmd.op == OP_WRITE_B);
  assign mismatch = clamp_dim(cfg.a_cols) != clamp_dim(cfg.b_rows);

  assign waddr   = AW'(AW'(q_cmd.row) * DIM_A) + AW'(q_cmd.col);
  assign wdata   = ELEM_WIDTH'(q_cmd.value);
  assign a_raddr = AW'(AW'(i) * DIM_A) + AW'(k);
  assign b_raddr = AW'(AW'(k) * DIM_A) + AW'(j);

  assign k_last    = (DIM_W'(k) + DIM_W'(1)) == ac;
  assign j_last    = (DIM_W'(j) + DIM_W'(1)) == bc;
  assign cell_last = ((DIM_W'(i) + DIM_W'(1)) == ar) && j_last;
  assign load      = (state == ST_EMIT) && (!out_valid || out_ready);

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = mismatch ? ST_EMIT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          state_next = (err || cell_last) ? ST_IDLE : ST_ISSUE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == ST_ISSUE);
      s2_valid <= s1_valid;
      if (load) begin
        done <= 1'b0;
      end else if (s2_valid && s2_last) begin
        done <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar  <= clamp_dim(cfg.a_rows);
      ac  <= clamp_dim(cfg.a_cols);
      bc  <= clamp_dim(cfg.b_cols);
      err <= mismatch;
      i   <= '0;
      j   <= '0;
      k   <= '0;
    end
    if (state == ST_ISSUE) begin
      k <= k + IDX_W'(1);
    end
    s1_first <= (k == '0);
    s1_last  <= k_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= $signed(a_rd) * $signed(b_rd);
    if (s2_valid) begin
      acc <= (s2_first ? '0 : acc) + ACC_W'(prod);
    end
    if (load) begin
      out_row   <= i;
      out_col   <= j;
      out_value <= err ? '0 : acc;
      out_last  <= err || cell_last;
      out_err   <= err;
      k         <= '0;
      if (j_last) begin
        j <= '0;
        i <= i + IDX_W'(1);
      end else begin
        j <= j + IDX_W'(1);
      end
    end
  end

endmodule
